>>> rtl/core/mctxn_pkg.sv
// Shared constants, types and the period table for the pattern cell to note cell converter.
// No dependencies; every module of the block refers to this package by scoped names.

package mctxn_pkg;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned PERIOD_W = 12;
   localparam int unsigned NOTE_W   = 7;
   localparam int unsigned EFX_W    = 4;
   localparam int unsigned RULES_W  = 2;

   // Period table: 96 descending entries, widest entry needs 13 bits.
   localparam int unsigned TABLE_LEN = 96;
   localparam int unsigned TABLE_W   = 13;
   localparam logic [NOTE_W-1:0] NOTE_NONE = 7'd0;
   localparam logic [NOTE_W-1:0] NOTE_MAX  = 7'd96;

   localparam logic [TABLE_W-1:0] PERIOD_TABLE [TABLE_LEN] = '{
      13'd6848, 13'd6464, 13'd6096, 13'd5760, 13'd5424, 13'd5120,
      13'd4832, 13'd4560, 13'd4304, 13'd4064, 13'd3840, 13'd3624,
      13'd3424, 13'd3232, 13'd3048, 13'd2880, 13'd2712, 13'd2560,
      13'd2416, 13'd2280, 13'd2152, 13'd2032, 13'd1920, 13'd1812,
      13'd1712, 13'd1616, 13'd1524, 13'd1440, 13'd1356, 13'd1280,
      13'd1208, 13'd1140, 13'd1076, 13'd1016, 13'd960,  13'd906,
      13'd856,  13'd808,  13'd762,  13'd720,  13'd678,  13'd640,
      13'd604,  13'd570,  13'd538,  13'd508,  13'd480,  13'd453,
      13'd428,  13'd404,  13'd381,  13'd360,  13'd339,  13'd320,
      13'd302,  13'd285,  13'd269,  13'd254,  13'd240,  13'd226,
      13'd214,  13'd202,  13'd190,  13'd180,  13'd170,  13'd160,
      13'd151,  13'd143,  13'd135,  13'd127,  13'd120,  13'd113,
      13'd107,  13'd101,  13'd95,   13'd90,   13'd85,   13'd80,
      13'd75,   13'd71,   13'd67,   13'd63,   13'd60,   13'd56,
      13'd53,   13'd50,   13'd47,   13'd45,   13'd42,   13'd40,
      13'd37,   13'd35,   13'd33,   13'd31,   13'd30,   13'd28
   };

   // Effect command codes.
   localparam logic [EFX_W-1:0] EFX_NONE       = 4'h0;
   localparam logic [EFX_W-1:0] EFX_SLIDE_UP   = 4'h1;
   localparam logic [EFX_W-1:0] EFX_SLIDE_DOWN = 4'h2;
   localparam logic [EFX_W-1:0] EFX_TONE_PORTA = 4'h3;
   localparam logic [EFX_W-1:0] EFX_VIBRATO    = 4'h4;
   localparam logic [EFX_W-1:0] EFX_PORTA_VOL  = 4'h5;
   localparam logic [EFX_W-1:0] EFX_VIB_VOL    = 4'h6;
   localparam logic [EFX_W-1:0] EFX_VOL_SLIDE  = 4'hA;
   localparam logic [EFX_W-1:0] EFX_VOLUME     = 4'hC;
   localparam logic [EFX_W-1:0] EFX_BREAK      = 4'hD;
   localparam logic [EFX_W-1:0] EFX_EXTENDED   = 4'hE;
   localparam logic [EFX_W-1:0] EFX_SPEED      = 4'hF;

   // Parameter limits and the extended sub-commands that are dropped.
   localparam logic [BYTE_W-1:0] PRM_ZERO       = 8'h00;
   localparam logic [BYTE_W-1:0] PRM_VOLUME_MAX = 8'd64;
   localparam logic [BYTE_W-1:0] PRM_SPEED_MAX  = 8'h1F;
   localparam logic [BYTE_W-1:0] PRM_EXT_FILTER = 8'h10;
   localparam logic [BYTE_W-1:0] PRM_EXT_GLISS  = 8'h20;
   localparam logic [BYTE_W-1:0] PRM_EXT_VOL_UP = 8'hA0;
   localparam logic [BYTE_W-1:0] PRM_EXT_VOL_DN = 8'hB0;

   // Fixup family selected by the configuration register.
   localparam logic [RULES_W-1:0] RULES_STANDARD = 2'd0;
   localparam logic [RULES_W-1:0] RULES_ALT1     = 2'd1;
   localparam logic [RULES_W-1:0] RULES_ALT2     = 2'd2;

   // Effect command together with its parameter.
   typedef struct packed {
      logic [EFX_W-1:0]  effect;
      logic [BYTE_W-1:0] param;
   } effect_cell_type;

endpackage

>>> rtl/core/mctxn_period_lookup.sv
// Period to note lookup: 96 parallel compares against the constant period table.
// Depends on mctxn_pkg for the table and widths.

module mctxn_period_lookup (
   input  logic [mctxn_pkg::PERIOD_W-1:0] period,
   output logic [mctxn_pkg::NOTE_W-1:0]   note
);

   logic [mctxn_pkg::TABLE_LEN-1:0] reach;

   // One comparator per table entry; the entries are independent.
   always_comb begin
      for (int i = 0; i < mctxn_pkg::TABLE_LEN; i++) begin
         reach[i] = {1'b0, period} >= mctxn_pkg::PERIOD_TABLE[i];
      end
   end

   // The first entry reached wins, so scan from the end and let lower indexes override.
   always_comb begin
      note = mctxn_pkg::NOTE_NONE;
      for (int i = mctxn_pkg::TABLE_LEN - 1; i >= 0; i--) begin
         if (reach[i]) begin
            note = mctxn_pkg::NOTE_W'(i + 1);
         end
      end
   end

endmodule

>>> rtl/core/mctxn_effect_fixup.sv
// Effect and parameter fixups: standard rules, then the family selected by the rules register.
// Depends on mctxn_pkg for effect codes, limits and the effect cell struct.

module mctxn_effect_fixup (
   input  mctxn_pkg::effect_cell_type        raw,
   input  logic [mctxn_pkg::RULES_W-1:0]     rules,
   output mctxn_pkg::effect_cell_type        fixed
);

   mctxn_pkg::effect_cell_type std;
   logic ext_dropped;

   // Extended sub-commands that the player does not support.
   assign ext_dropped = (raw.param == mctxn_pkg::PRM_EXT_FILTER) ||
                        (raw.param == mctxn_pkg::PRM_EXT_GLISS)  ||
                        (raw.param == mctxn_pkg::PRM_EXT_VOL_UP) ||
                        (raw.param == mctxn_pkg::PRM_EXT_VOL_DN);

   // Standard fixups; only the first rule that matches applies.
   always_comb begin
      std = raw;
      priority if (raw.effect == mctxn_pkg::EFX_VOLUME &&
                   raw.param > mctxn_pkg::PRM_VOLUME_MAX) begin
         std.param = mctxn_pkg::PRM_VOLUME_MAX;
      end else if ((raw.effect == mctxn_pkg::EFX_SLIDE_UP ||
                    raw.effect == mctxn_pkg::EFX_SLIDE_DOWN ||
                    raw.effect == mctxn_pkg::EFX_VOL_SLIDE) &&
                   raw.param == mctxn_pkg::PRM_ZERO) begin
         std.effect = mctxn_pkg::EFX_NONE;
      end else if (raw.effect == mctxn_pkg::EFX_PORTA_VOL &&
                   raw.param == mctxn_pkg::PRM_ZERO) begin
         std.effect = mctxn_pkg::EFX_TONE_PORTA;
      end else if (raw.effect == mctxn_pkg::EFX_VIB_VOL &&
                   raw.param == mctxn_pkg::PRM_ZERO) begin
         std.effect = mctxn_pkg::EFX_VIBRATO;
      end else if (raw.effect == mctxn_pkg::EFX_EXTENDED && ext_dropped) begin
         std.effect = mctxn_pkg::EFX_NONE;
         std.param  = mctxn_pkg::PRM_ZERO;
      end else begin
         std = raw;
      end
   end

   // Family fixes on top of the standard result; an unused mode behaves as standard.
   always_comb begin
      fixed = std;
      unique case (rules)
         mctxn_pkg::RULES_ALT1: begin
            if (std.effect == mctxn_pkg::EFX_BREAK) begin
               fixed.param = mctxn_pkg::PRM_ZERO;
            end
            if (std.effect == mctxn_pkg::EFX_SPEED && std.param == mctxn_pkg::PRM_ZERO) begin
               fixed.effect = mctxn_pkg::EFX_NONE;
            end
         end
         mctxn_pkg::RULES_ALT2: begin
            if (std.effect == mctxn_pkg::EFX_EXTENDED) begin
               fixed.effect = mctxn_pkg::EFX_NONE;
               fixed.param  = mctxn_pkg::PRM_ZERO;
            end
            if (std.effect == mctxn_pkg::EFX_SPEED &&
                std.param > mctxn_pkg::PRM_SPEED_MAX) begin
               fixed.param = mctxn_pkg::PRM_SPEED_MAX;
            end
         end
         default: begin
            fixed = std;
         end
      endcase
   end

endmodule

>>> rtl/core/mod_cell_to_xm_note_unit.sv
// Top level of the pattern cell to note cell converter: input register, lookup and fixups,
// result register. Depends on mctxn_pkg, mctxn_period_lookup and mctxn_effect_fixup.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_byte_zero .. req_byte_three (8 bits each)
//   rsp      out        rsp_valid/rsp_ready  rsp_note(7) rsp_instrument(8) rsp_effect(4)
//                                            rsp_effect_param(8)
//   csr      in         csr_valid/csr_ready  csr_data(2): effect rules mode
//
// An item passes two register stages: the input register, then the result register, where its
// result is valid until taken. One item is taken every cycle unless a stalled result fills both.
// The period lookup and effect fixups sit between the input register and the result register.
// A stalled result holds the result register, and the input register still takes one more
// item behind it. Reset is synchronous and clears the valid flags and the rules register.
// The configuration port is always ready.

module mod_cell_to_xm_note_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mctxn_pkg::BYTE_W-1:0]      req_byte_zero,
   input  logic [mctxn_pkg::BYTE_W-1:0]      req_byte_one,
   input  logic [mctxn_pkg::BYTE_W-1:0]      req_byte_two,
   input  logic [mctxn_pkg::BYTE_W-1:0]      req_byte_three,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mctxn_pkg::NOTE_W-1:0]      rsp_note,
   output logic [mctxn_pkg::BYTE_W-1:0]      rsp_instrument,
   output logic [mctxn_pkg::EFX_W-1:0]       rsp_effect,
   output logic [mctxn_pkg::BYTE_W-1:0]      rsp_effect_param,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mctxn_pkg::RULES_W-1:0]     csr_data
);

   logic [mctxn_pkg::RULES_W-1:0] rules_ff, rules_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic [mctxn_pkg::BYTE_W-1:0]  s1_b0_ff, s1_b1_ff, s1_b2_ff, s1_b3_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [mctxn_pkg::NOTE_W-1:0]  out_note_ff, out_note_in;
   logic [mctxn_pkg::BYTE_W-1:0]  out_instr_ff, out_instr_in;
   mctxn_pkg::effect_cell_type    out_efx_ff, out_efx_in;

   logic                          out_load;
   logic                          s1_load;
   logic [mctxn_pkg::PERIOD_W-1:0] period;
   mctxn_pkg::effect_cell_type    raw_efx;

   // Configuration register.
   assign csr_ready = 1'b1;
   assign rules_in  = (csr_valid && csr_ready) ? csr_data : rules_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_ff <= mctxn_pkg::RULES_STANDARD;
      end else begin
         rules_ff <= rules_in;
      end
   end

   // Flow control: the result register loads when empty or being drained.
   assign out_load    = !out_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_load;
   assign s1_load     = req_valid && req_ready;
   assign s1_valid_in = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_b0_ff <= req_byte_zero;
         s1_b1_ff <= req_byte_one;
         s1_b2_ff <= req_byte_two;
         s1_b3_ff <= req_byte_three;
      end
   end

   // Field extraction from the registered cell.
   assign period         = {s1_b0_ff[3:0], s1_b1_ff};
   assign out_instr_in   = {s1_b0_ff[7:4], s1_b2_ff[7:4]};
   assign raw_efx.effect = s1_b2_ff[3:0];
   assign raw_efx.param  = s1_b3_ff;

   mctxn_period_lookup u_lookup (
      .period (period),
      .note   (out_note_in)
   );

   mctxn_effect_fixup u_fixup (
      .raw   (raw_efx),
      .rules (rules_ff),
      .fixed (out_efx_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_note_ff  <= out_note_in;
         out_instr_ff <= out_instr_in;
         out_efx_ff   <= out_efx_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_note         = out_note_ff;
   assign rsp_instrument   = out_instr_ff;
   assign rsp_effect       = out_efx_ff.effect;
   assign rsp_effect_param = out_efx_ff.param;

   // A cell waiting behind a stalled result must not be lost.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("input register dropped an item behind a stalled result");

   // Backpressure on the input only when both registers are occupied.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline has room");

   // The lookup never produces a note past the table.
   a_note_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_note_ff <= mctxn_pkg::NOTE_MAX))
      else $error("note out of range");

   // A result follows every registered cell when the output is free.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load) |=> out_valid_ff)
      else $error("registered item did not reach the result register");

endmodule
